>>> sv/receive_line_fifo_top_defines.svh
// Assertion macros for the receive line FIFO.
`ifndef RECEIVE_LINE_FIFO_TOP_DEFINES_SVH
`define RECEIVE_LINE_FIFO_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define RLF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rlf: implication check failed");
// Next-cycle implication.
`define RLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rlf: next-cycle check failed");
`else
`define RLF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RLF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/rlf_pkg.sv
`default_nettype none
package rlf_pkg;

	localparam int BYTE_W = 8;
	localparam int STAT_W = 7;

	// operation codes
	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	localparam logic [BYTE_W-1:0] LINE_FEED = 8'h0A;

endpackage
`default_nettype wire

>>> sv/rlf_req_if.sv
`default_nettype none
interface rlf_req_if;
	import rlf_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink   (input valid, input operation, input rx_byte, output ready);

endinterface
`default_nettype wire

>>> sv/rlf_rsp_if.sv
`default_nettype none
interface rlf_rsp_if;
	import rlf_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_line;
	logic              read_empty;
	logic              overflow;
	logic [STAT_W-1:0] fill_level;
	logic [STAT_W-1:0] lines_waiting;
	logic              line_ready;

	modport source (
		output valid, output data_byte, output end_of_line, output read_empty,
		output overflow, output fill_level, output lines_waiting, output line_ready,
		input ready
	);
	modport sink (
		input valid, input data_byte, input end_of_line, input read_empty,
		input overflow, input fill_level, input lines_waiting, input line_ready,
		output ready
	);

endinterface
`default_nettype wire

>>> sv/receive_line_fifo_top.sv
// Channel | Dir | Beat carries
// --------+-----+--------------------------------------------------------------
// req     | in  | operation (0 receive, 1 read), rx_byte
// rsp     | out | data_byte, end_of_line, read_empty, overflow, fill_level,
//         |     | lines_waiting, line_ready
//
// One beat per cycle on req while rsp drains; each result is held in the
// result stage register, fed by the registered read of the byte store.
// The line count is committed as each result leaves, once the popped byte is
// known. arst_n clears pointers, counts and the result valid; the byte store
// and result payload are not reset. A stalled rsp holds its beat, drops req.ready.
`default_nettype none
`include "receive_line_fifo_top_defines.svh"
module receive_line_fifo_top #(
	parameter int DEPTH = 64
) (
	input  wire       clk,
	input  wire       arst_n,
	rlf_req_if.sink   req,
	rlf_rsp_if.source rsp
);
	import rlf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [BYTE_W-1:0] mem [DEPTH];

	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] line_q;

	logic              valid_s1;
	logic              pop_s1;
	logic              push_lf_s1;
	logic              empty_s1;
	logic              ovf_s1;
	logic [CW-1:0]     fill_s1;
	logic [BYTE_W-1:0] rd_data_s1;

	logic          in_fire;
	logic          out_fire;
	logic          full;
	logic          is_read;
	logic          do_push;
	logic          do_pop;
	logic          pop_lf;
	logic [CW-1:0] lines_next;

	// handshake and step decode
	assign out_fire  = valid_s1 && rsp.ready;
	assign req.ready = !valid_s1 || rsp.ready;
	assign in_fire   = req.valid && req.ready;
	assign full      = (count_q == CW'(DEPTH));
	assign is_read   = (req.operation == OP_READ);
	assign do_push   = in_fire && !is_read && !full;
	assign do_pop    = in_fire && is_read && (count_q != '0);

	// byte store: write on push, registered read on pop
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= req.rx_byte;
		end
		if (do_pop) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	// pointers and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end else if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pop_s1     <= do_pop;
			push_lf_s1 <= do_push && (req.rx_byte == LINE_FEED);
			empty_s1   <= is_read && (count_q == '0);
			ovf_s1     <= !is_read && full;
			if (do_push) begin
				fill_s1 <= count_q + 1'b1;
			end else if (do_pop) begin
				fill_s1 <= count_q - 1'b1;
			end else begin
				fill_s1 <= count_q;
			end
		end
	end

	// line count after the step in the result stage
	assign pop_lf = pop_s1 && (rd_data_s1 == LINE_FEED);
	always_comb begin
		lines_next = line_q;
		if (push_lf_s1) begin
			lines_next = line_q + 1'b1;
		end else if (pop_lf && (line_q != '0)) begin
			lines_next = line_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
		end else if (out_fire) begin
			line_q <= lines_next;
		end
	end

	// result beat
	assign rsp.valid         = valid_s1;
	assign rsp.data_byte     = pop_s1 ? rd_data_s1 : '0;
	assign rsp.end_of_line   = pop_lf;
	assign rsp.read_empty    = empty_s1;
	assign rsp.overflow      = ovf_s1;
	assign rsp.fill_level    = STAT_W'(fill_s1);
	assign rsp.lines_waiting = STAT_W'(lines_next);
	assign rsp.line_ready    = (lines_next != '0);

	// checks
	`RLF_ASSERT_IMPLY(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`RLF_ASSERT_IMPLY(a_lines_le_fill, clk, arst_n, valid_s1, lines_next <= fill_s1)
	`RLF_ASSERT_NEXT(a_push_counts, clk, arst_n, do_push, count_q == $past(count_q) + 1'b1)

endmodule
`default_nettype wire

>>> sim/rlf_line_checker.sv
module rlf_line_checker #(
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	rlf_req_if   req_mon,
	rlf_rsp_if   rsp_mon,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import rlf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_line;
		logic              read_empty;
		logic              overflow;
		logic [STAT_W-1:0] fill_level;
		logic [STAT_W-1:0] lines_waiting;
		logic              line_ready;
	} line_status_t;

	// shadow copy of the FIFO
	logic [BYTE_W-1:0] shadow_bytes [DEPTH];
	logic [PTR_W-1:0]  shadow_rd_ptr;
	logic [STAT_W-1:0] shadow_fill;
	logic [STAT_W-1:0] shadow_lines;

	line_status_t expected_status_q[$];

	// apply one request beat to the shadow FIFO, return the status it yields
	function automatic line_status_t apply_fifo_beat(logic op, logic [BYTE_W-1:0] b);
		line_status_t s;
		logic [PTR_W-1:0] wr_pos;
		s = '0;
		if (op == OP_RECEIVE) begin
			if (shadow_fill < DEPTH) begin
				wr_pos = shadow_rd_ptr + shadow_fill[PTR_W-1:0];
				shadow_bytes[wr_pos] = b;
				shadow_fill = shadow_fill + 1'b1;
				if (b == LINE_FEED)
					shadow_lines = shadow_lines + 1'b1;
			end else begin
				s.overflow = 1'b1;
			end
		end else begin
			if (shadow_fill != 0) begin
				s.data_byte = shadow_bytes[shadow_rd_ptr];
				shadow_rd_ptr = shadow_rd_ptr + 1'b1;
				shadow_fill = shadow_fill - 1'b1;
				if (s.data_byte == LINE_FEED) begin
					s.end_of_line = 1'b1;
					if (shadow_lines != 0)
						shadow_lines = shadow_lines - 1'b1;
				end
			end else begin
				s.read_empty = 1'b1;
			end
		end
		s.fill_level    = shadow_fill;
		s.lines_waiting = shadow_lines;
		s.line_ready    = (shadow_lines != 0);
		return s;
	endfunction

	// compare result beats, then queue the prediction for each request beat
	always @(posedge clk or negedge arst_n) begin
		line_status_t got;
		line_status_t want;
		if (!arst_n) begin
			shadow_rd_ptr = '0;
			shadow_fill   = '0;
			shadow_lines  = '0;
			expected_status_q.delete();
			mismatches    = 0;
			outstanding   = 0;
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				got.data_byte     = rsp_mon.data_byte;
				got.end_of_line   = rsp_mon.end_of_line;
				got.read_empty    = rsp_mon.read_empty;
				got.overflow      = rsp_mon.overflow;
				got.fill_level    = rsp_mon.fill_level;
				got.lines_waiting = rsp_mon.lines_waiting;
				got.line_ready    = rsp_mon.line_ready;
				if (expected_status_q.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("[%0t] unexpected rsp beat: data=%02h eol=%b empty=%b ovf=%b fill=%0d lines=%0d rdy=%b",
							$time, got.data_byte, got.end_of_line, got.read_empty,
							got.overflow, got.fill_level, got.lines_waiting, got.line_ready);
				end else begin
					want = expected_status_q.pop_front();
					if (got !== want) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("[%0t] rsp mismatch: exp data=%02h eol=%b empty=%b ovf=%b fill=%0d lines=%0d rdy=%b | got data=%02h eol=%b empty=%b ovf=%b fill=%0d lines=%0d rdy=%b",
								$time, want.data_byte, want.end_of_line, want.read_empty,
								want.overflow, want.fill_level, want.lines_waiting, want.line_ready,
								got.data_byte, got.end_of_line, got.read_empty,
								got.overflow, got.fill_level, got.lines_waiting, got.line_ready);
					end
				end
			end
			if (req_mon.valid && req_mon.ready)
				expected_status_q.push_back(apply_fifo_beat(req_mon.operation, req_mon.rx_byte));
			outstanding = expected_status_q.size();
		end
	end

endmodule

>>> sim/receive_line_fifo_top_tb.sv
module receive_line_fifo_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rlf_pkg::*;

	localparam int DEPTH       = 64;
	localparam int ITEM_TARGET = 1550;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT     = 700;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rlf_req_if req_ch();
	rlf_rsp_if rsp_ch();

	int mismatch_count;
	int results_pending;
	int beats_sent;
	int burst_left;
	int cycle_count = 0;

	// long receiver hold-off
	logic hold_go;
	logic hold_done;
	int   hold_left;

	// receiver stall pattern
	int ready_mode;
	int mode_left;

	receive_line_fifo_top #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rlf_line_checker #(.DEPTH(DEPTH)) line_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_mon     (req_ch),
		.rsp_mon     (rsp_ch),
		.mismatches  (mismatch_count),
		.outstanding (results_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: mode-based stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
			ready_mode   <= 0;
			mode_left    <= 0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_left    <= HOLD_CYCLES;
			hold_done    <= 1'b1;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(10, 150);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
				default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// offer one beat, wait for it to be taken, and sometimes idle between bursts
	task automatic push_beat(input logic op, input logic [BYTE_W-1:0] b);
		int gap;
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.rx_byte   <= b;
		do @(posedge clk); while (!req_ch.ready);
		beats_sent = beats_sent + 1;
		if (beats_sent == HOLD_AT)
			hold_go <= 1'b1;
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(60, 200);
			else
				burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid     <= 1'b0;
				req_ch.operation <= 1'($urandom_range(0, 1));
				req_ch.rx_byte   <= BYTE_W'($urandom_range(0, 255));
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// byte with a given percent chance of being a linefeed
	function automatic logic [BYTE_W-1:0] pick_byte(int lf_pct);
		logic [BYTE_W-1:0] b;
		if ($urandom_range(0, 99) < lf_pct)
			return LINE_FEED;
		b = BYTE_W'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic read_bytes(input int n);
		repeat (n) push_beat(OP_READ, BYTE_W'($urandom_range(0, 255)));
	endtask

	// a line of random text closed by a linefeed
	task automatic send_line(input int len);
		logic [BYTE_W-1:0] b;
		repeat (len) begin
			b = BYTE_W'($urandom_range(0, 255));
			if (b == LINE_FEED)
				b = b ^ 8'h01;
			push_beat(OP_RECEIVE, b);
		end
		push_beat(OP_RECEIVE, LINE_FEED);
	endtask

	initial begin
		int pick;
		int lf_pct;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_RECEIVE;
		req_ch.rx_byte   = '0;
		hold_go          = 1'b0;
		beats_sent       = 0;
		burst_left       = 8;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: read on empty, byte extremes, linefeeds, drain past empty
		push_beat(OP_READ, 8'hFF);
		push_beat(OP_RECEIVE, 8'hFF);
		push_beat(OP_RECEIVE, 8'h00);
		push_beat(OP_RECEIVE, LINE_FEED);
		push_beat(OP_RECEIVE, 8'h55);
		push_beat(OP_RECEIVE, 8'hAA);
		push_beat(OP_RECEIVE, LINE_FEED);
		push_beat(OP_RECEIVE, 8'h0B);
		push_beat(OP_RECEIVE, 8'h09);
		read_bytes(9);
		push_beat(OP_READ, 8'h00);

		// random episodes
		while (beats_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_line($urandom_range(0, 20));
				read_bytes($urandom_range(0, 12));
			end else if (pick < 55) begin
				read_bytes($urandom_range(1, 25));
			end else if (pick < 95) begin
				lf_pct = $urandom_range(0, 40);
				repeat ($urandom_range(1, 20))
					push_beat(1'($urandom_range(0, 1)), pick_byte(lf_pct));
			end else begin
				// fill past full, then drain past empty
				lf_pct = ($urandom_range(0, 1) == 0) ? 100 : $urandom_range(0, 30);
				repeat (DEPTH + $urandom_range(2, 8))
					push_beat(OP_RECEIVE, pick_byte(lf_pct));
				read_bytes(DEPTH + $urandom_range(2, 8));
			end
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && results_pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> receive_line_fifo_top.f
+incdir+sv
sv/rlf_pkg.sv
sv/rlf_req_if.sv
sv/rlf_rsp_if.sv
sv/receive_line_fifo_top.sv
sim/rlf_line_checker.sv
sim/receive_line_fifo_top_tb.sv
